### src/hnp_pkg.sv
// ----------------------------------------------------------------------------
// hnp_pkg
// Shared types, syntax positions and the field width table for the HEVC NAL
// header parser.
// ----------------------------------------------------------------------------
package hnp_pkg;

  localparam int MAX_SUB_LAYERS_DEF = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int POS_W = 7;

  localparam logic [POS_W-1:0] POS_NUT            = 7'd1;
  localparam logic [POS_W-1:0] POS_TID            = 7'd3;
  localparam logic [POS_W-1:0] POS_VPS_ID         = 7'd4;
  localparam logic [POS_W-1:0] POS_VPS_RES16      = 7'd9;
  localparam logic [POS_W-1:0] POS_SPS_VPS_ID     = 7'd10;
  localparam logic [POS_W-1:0] POS_SPS_MAX_SUB    = 7'd11;
  localparam logic [POS_W-1:0] POS_GEN_COMPAT     = 7'd16;
  localparam logic [POS_W-1:0] POS_GEN_LEVEL      = 7'd23;
  localparam logic [POS_W-1:0] POS_SUB_PROF_PRES  = 7'd24;
  localparam logic [POS_W-1:0] POS_SUB_LEVEL_PRES = 7'd25;
  localparam logic [POS_W-1:0] POS_SUB_RESERVED   = 7'd26;
  localparam logic [POS_W-1:0] POS_SUB_PROFILE    = 7'd27;
  localparam logic [POS_W-1:0] POS_SUB_COMPAT     = 7'd30;
  localparam logic [POS_W-1:0] POS_SUB_RES12      = 7'd36;
  localparam logic [POS_W-1:0] POS_SUB_LEVEL      = 7'd37;
  localparam logic [POS_W-1:0] POS_SPS_ID         = 7'd38;
  localparam logic [POS_W-1:0] POS_CHROMA         = 7'd39;
  localparam logic [POS_W-1:0] POS_SEP_PLANE      = 7'd40;
  localparam logic [POS_W-1:0] POS_PIC_WIDTH      = 7'd41;
  localparam logic [POS_W-1:0] POS_PIC_HEIGHT     = 7'd42;
  localparam logic [POS_W-1:0] POS_PPS_ID         = 7'd43;
  localparam logic [POS_W-1:0] POS_PPS_CABAC      = 7'd49;
  localparam logic [POS_W-1:0] POS_SLICE_FIRST    = 7'd50;
  localparam logic [POS_W-1:0] POS_NO_OUTPUT      = 7'd51;
  localparam logic [POS_W-1:0] POS_SLICE_PPS      = 7'd52;
  localparam logic [POS_W-1:0] POS_END            = 7'd53;
  localparam logic [POS_W-1:0] POS_DONE           = 7'd64;

  localparam logic [5:0] ID_STATUS = 6'd53;
  localparam logic [5:0] NUT_VPS   = 6'd32;
  localparam logic [5:0] NUT_SPS   = 6'd33;
  localparam logic [5:0] NUT_PPS   = 6'd34;
  localparam logic [5:0] NUT_EOS   = 6'd36;
  localparam logic [5:0] NUT_EOB   = 6'd37;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT   = 2'd1;
  localparam logic [1:0] ST_EG_OVERFLOW = 2'd2;

  localparam logic [5:0] WIDTH_UE = 6'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       keep;
    logic       last;
    logic       head;
  } q_entry_t;

  typedef struct packed {
    logic [5:0]  id;
    logic [31:0] value;
    logic [2:0]  sub;
    logic [4:0]  fidx;
    logic [1:0]  status;
  } result_t;

  function automatic logic [5:0] field_width(input logic [POS_W-1:0] pos);
    logic [5:0] w;
    begin
      unique case (pos)
        7'd0: w = 6'd1;
        7'd1: w = 6'd6;
        7'd2: w = 6'd6;
        7'd3: w = 6'd3;
        7'd4: w = 6'd4;
        7'd5: w = 6'd2;
        7'd6: w = 6'd6;
        7'd7: w = 6'd3;
        7'd8: w = 6'd1;
        7'd9: w = 6'd16;
        7'd10: w = 6'd4;
        7'd11: w = 6'd3;
        7'd12: w = 6'd1;
        7'd13, 7'd27: w = 6'd2;
        7'd14, 7'd28: w = 6'd1;
        7'd15, 7'd29: w = 6'd5;
        7'd16, 7'd30: w = 6'd32;
        7'd17, 7'd31: w = 6'd1;
        7'd18, 7'd32: w = 6'd1;
        7'd19, 7'd33: w = 6'd1;
        7'd20, 7'd34: w = 6'd1;
        7'd21, 7'd35: w = 6'd32;
        7'd22, 7'd36: w = 6'd12;
        7'd23, 7'd37: w = 6'd8;
        7'd24: w = 6'd1;
        7'd25: w = 6'd1;
        7'd26: w = 6'd2;
        7'd40: w = 6'd1;
        7'd45: w = 6'd1;
        7'd46: w = 6'd1;
        7'd47: w = 6'd3;
        7'd48: w = 6'd1;
        7'd49: w = 6'd1;
        7'd50: w = 6'd1;
        7'd51: w = 6'd1;
        default: w = WIDTH_UE;
      endcase
      return w;
    end
  endfunction

endpackage

### src/hnp_front.sv
// ----------------------------------------------------------------------------
// hnp_front
// Takes raw NAL bytes, tracks the byte position and marks emulation
// prevention bytes, and queues each byte with its classification.
// ----------------------------------------------------------------------------
module hnp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               unit_end,
  input  logic               queue_full,
  output logic               push,
  output hnp_pkg::q_entry_t  push_entry
);

  logic [2:0] byte_count;
  logic [2:0] byte_count_next;
  logic [1:0] zero_run;
  logic [1:0] zero_run_next;
  logic       in_payload;
  logic       keep;

  assign byte_stall = queue_full;
  assign push = byte_valid && !queue_full;
  assign in_payload = (byte_count >= 3'd2);

  always_comb begin
    keep = 1'b1;
    zero_run_next = zero_run;
    byte_count_next = byte_count;
    if (in_payload) begin
      if (zero_run == 2'd2 && data_byte == 8'd3) begin
        keep = 1'b0;
        zero_run_next = 2'd0;
      end else if (data_byte == 8'd0) begin
        if (zero_run != 2'd2) begin
          zero_run_next = 2'(zero_run + 2'd1);
        end
      end else begin
        zero_run_next = 2'd0;
      end
    end
    if (byte_count != 3'd7) begin
      byte_count_next = 3'(byte_count + 3'd1);
    end
    if (unit_end) begin
      byte_count_next = 3'd0;
      zero_run_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= 3'd0;
      zero_run <= 2'd0;
    end else if (push) begin
      byte_count <= byte_count_next;
      zero_run <= zero_run_next;
    end
  end

  assign push_entry.data_byte = data_byte;
  assign push_entry.keep = keep;
  assign push_entry.last = unit_end;
  assign push_entry.head = !in_payload;

endmodule

### src/hnp_queue.sv
// ----------------------------------------------------------------------------
// hnp_queue
// Small register queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hnp_queue #(
  parameter int DEPTH = hnp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hnp_pkg::q_entry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output hnp_pkg::q_entry_t  head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hnp_pkg::q_entry_t slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : PW'(wptr + 1'b1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : PW'(rptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

### src/hnp_back.sv
// ----------------------------------------------------------------------------
// hnp_back
// Bit-serial syntax walker: one payload bit per cycle while no stalled result
// holds it, one result at most per cycle, with a hold register that settles
// the last-result mark.
module hnp_back #(
  parameter int MAX_SUB_LAYERS = hnp_pkg::MAX_SUB_LAYERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ent_valid,
  input  hnp_pkg::q_entry_t  ent,
  output logic               pop,
  output logic               element_valid,
  input  logic               element_stall,
  output logic [5:0]         element_id,
  output logic [31:0]        element_value,
  output logic [2:0]         sub_layer,
  output logic [4:0]         flag_index,
  output logic [1:0]         status,
  output logic               run_last
);

  localparam int LIW = $clog2(MAX_SUB_LAYERS + 1);
  localparam int FIW = (MAX_SUB_LAYERS > 1) ? $clog2(MAX_SUB_LAYERS) : 1;
  localparam int PW = hnp_pkg::POS_W;

  logic [PW-1:0]             pos, pos_next;
  logic [5:0]                unit_type, unit_type_next;
  logic [31:0]               acc, acc_next;
  logic [5:0]                gath, gath_next;
  logic [5:0]                lzc, lzc_next;
  logic [2:0]                slc, slc_next;
  logic [LIW-1:0]            li, li_next;
  logic [MAX_SUB_LAYERS-1:0] prof, prof_next;
  logic [MAX_SUB_LAYERS-1:0] lev, lev_next;
  logic [1:0]                chroma, chroma_next;
  logic [2:0]                bitcnt;
  logic                      bits_done;

  logic                      hold_valid;
  logic                      hold_final;
  hnp_pkg::result_t          hold;

  logic                      out_free;
  logic                      step_go;
  logic                      is_end;
  logic                      cur_bit;
  logic                      produce;
  hnp_pkg::result_t          res;
  logic                      hold_out;
  logic                      do_c;
  logic [31:0]               cv;
  logic [31:0]               acc_sh;
  logic [5:0]                gath_inc;
  logic [5:0]                w;
  logic [2:0]                sub;
  logic [FIW-1:0]            li_idx;
  logic [LIW:0]              start;
  logic [LIW:0]              li_inc;
  logic                      found;
  logic [LIW-1:0]            sel;
  logic [PW-1:0]             search_pos;

  assign out_free = !element_valid || !element_stall;
  assign step_go = ent_valid && (!hold_valid || out_free);
  assign is_end = bits_done || !ent.keep || (pos >= hnp_pkg::POS_END);
  assign cur_bit = ent.data_byte[bitcnt];
  assign pop = step_go && (is_end || (bitcnt == 3'd0 && !ent.last));
  assign hold_out = hold_valid && out_free && (hold_final || produce);

  assign w = hnp_pkg::field_width(pos);
  assign sub = (pos >= hnp_pkg::POS_SUB_PROF_PRES && pos <= hnp_pkg::POS_SUB_LEVEL) ?
               3'(li) : 3'd7;
  assign li_idx = li[FIW-1:0];
  assign acc_sh = {acc[30:0], cur_bit};
  assign gath_inc = 6'(gath + 6'd1);
  assign li_inc = (LIW + 1)'(li) + 1'b1;
  assign start = (pos == hnp_pkg::POS_SUB_RESERVED) ? '0 : li_inc;

  always_comb begin
    found = 1'b0;
    sel = '0;
    for (int j = 0; j < MAX_SUB_LAYERS; j++) begin
      if (!found && j >= start && j < slc && (prof[j] || lev[j])) begin
        found = 1'b1;
        sel = LIW'(j);
      end
    end
    if (!found) begin
      search_pos = hnp_pkg::POS_SPS_ID;
    end else if (prof[sel[FIW-1:0]]) begin
      search_pos = hnp_pkg::POS_SUB_PROFILE;
    end else begin
      search_pos = hnp_pkg::POS_SUB_LEVEL;
    end
  end

  always_comb begin
    pos_next = pos;
    unit_type_next = unit_type;
    acc_next = acc;
    gath_next = gath;
    lzc_next = lzc;
    slc_next = slc;
    li_next = li;
    prof_next = prof;
    lev_next = lev;
    chroma_next = chroma;
    produce = 1'b0;
    res = '0;
    do_c = 1'b0;
    cv = '0;
    if (step_go && is_end) begin
      if (ent.last) begin
        if (ent.head && unit_type != hnp_pkg::NUT_EOS && unit_type != hnp_pkg::NUT_EOB) begin
          produce = 1'b1;
          res = '{hnp_pkg::ID_STATUS, 32'd0, 3'd7, 5'd0, hnp_pkg::ST_TOO_SHORT};
        end
        pos_next = '0;
        acc_next = '0;
        gath_next = '0;
        lzc_next = '0;
        li_next = '0;
      end
    end else if (step_go) begin
      if (pos == hnp_pkg::POS_GEN_COMPAT || pos == hnp_pkg::POS_SUB_COMPAT) begin
        produce = 1'b1;
        res = '{6'(pos), 32'(cur_bit), sub, gath[4:0], hnp_pkg::ST_OK};
        if (gath == 6'd31) begin
          gath_next = '0;
          pos_next = PW'(pos + 1'b1);
        end else begin
          gath_next = gath_inc;
        end
      end else if (w == hnp_pkg::WIDTH_UE) begin
        if (acc == '0) begin
          if (!cur_bit) begin
            if (lzc == 6'd31) begin
              produce = 1'b1;
              res = '{6'(pos), 32'hFFFF_FFFF, sub, 5'd0, hnp_pkg::ST_EG_OVERFLOW};
              lzc_next = '0;
              pos_next = hnp_pkg::POS_DONE;
            end else begin
              lzc_next = 6'(lzc + 6'd1);
            end
          end else if (lzc == '0) begin
            do_c = 1'b1;
          end else begin
            acc_next = 32'd1;
            gath_next = '0;
          end
        end else if (gath_inc >= lzc) begin
          do_c = 1'b1;
          cv = acc_sh - 32'd1;
          acc_next = '0;
          gath_next = '0;
          lzc_next = '0;
        end else begin
          acc_next = acc_sh;
          gath_next = gath_inc;
        end
      end else if (gath_inc >= w) begin
        do_c = 1'b1;
        cv = acc_sh;
        acc_next = '0;
        gath_next = '0;
      end else begin
        acc_next = acc_sh;
        gath_next = gath_inc;
      end
    end

    if (do_c) begin
      produce = 1'b1;
      res = '{6'(pos), cv, sub, 5'd0, hnp_pkg::ST_OK};
      pos_next = PW'(pos + 1'b1);
      case (pos)
        hnp_pkg::POS_NUT: unit_type_next = cv[5:0];
        hnp_pkg::POS_TID: begin
          if (unit_type == hnp_pkg::NUT_VPS) begin
            pos_next = hnp_pkg::POS_VPS_ID;
          end else if (unit_type == hnp_pkg::NUT_SPS) begin
            pos_next = hnp_pkg::POS_SPS_VPS_ID;
          end else if (unit_type == hnp_pkg::NUT_PPS) begin
            pos_next = hnp_pkg::POS_PPS_ID;
          end else if (unit_type <= 6'd9 || (unit_type >= 6'd16 && unit_type <= 6'd21)) begin
            pos_next = hnp_pkg::POS_SLICE_FIRST;
          end else begin
            pos_next = hnp_pkg::POS_DONE;
          end
        end
        hnp_pkg::POS_VPS_RES16, hnp_pkg::POS_PIC_HEIGHT, hnp_pkg::POS_PPS_CABAC,
        hnp_pkg::POS_SLICE_PPS: pos_next = hnp_pkg::POS_DONE;
        hnp_pkg::POS_SPS_MAX_SUB: begin
          slc_next = (cv > 32'(MAX_SUB_LAYERS - 1)) ? 3'(MAX_SUB_LAYERS - 1) : cv[2:0];
        end
        hnp_pkg::POS_GEN_LEVEL: begin
          li_next = '0;
          pos_next = (slc != 3'd0) ? hnp_pkg::POS_SUB_PROF_PRES : hnp_pkg::POS_SPS_ID;
        end
        hnp_pkg::POS_SUB_PROF_PRES: begin
          prof_next[li_idx] = cv[0];
          lev_next[li_idx] = 1'b0;
        end
        hnp_pkg::POS_SUB_LEVEL_PRES: begin
          lev_next[li_idx] = lev[li_idx] | cv[0];
          if (li_inc < (LIW + 1)'(slc)) begin
            li_next = LIW'(li_inc);
            pos_next = hnp_pkg::POS_SUB_PROF_PRES;
          end else begin
            li_next = LIW'(slc);
            pos_next = hnp_pkg::POS_SUB_RESERVED;
          end
        end
        hnp_pkg::POS_SUB_RESERVED: begin
          if (li_inc < (LIW + 1)'(MAX_SUB_LAYERS)) begin
            li_next = LIW'(li_inc);
            pos_next = hnp_pkg::POS_SUB_RESERVED;
          end else begin
            li_next = found ? sel : li;
            pos_next = search_pos;
          end
        end
        hnp_pkg::POS_SUB_RES12: begin
          if (lev[li_idx]) begin
            pos_next = hnp_pkg::POS_SUB_LEVEL;
          end else begin
            li_next = found ? sel : li;
            pos_next = search_pos;
          end
        end
        hnp_pkg::POS_SUB_LEVEL: begin
          li_next = found ? sel : li;
          pos_next = search_pos;
        end
        hnp_pkg::POS_CHROMA: begin
          chroma_next = (cv <= 32'd3) ? cv[1:0] : 2'd0;
          pos_next = (chroma_next == 2'd3) ? hnp_pkg::POS_SEP_PLANE : hnp_pkg::POS_PIC_WIDTH;
        end
        hnp_pkg::POS_SLICE_FIRST: begin
          pos_next = (unit_type >= 6'd16 && unit_type <= 6'd23) ?
                     hnp_pkg::POS_NO_OUTPUT : hnp_pkg::POS_SLICE_PPS;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      unit_type <= '0;
      acc <= '0;
      gath <= '0;
      lzc <= '0;
      slc <= '0;
      li <= '0;
      chroma <= '0;
      bitcnt <= 3'd7;
      bits_done <= 1'b0;
      hold_valid <= 1'b0;
      hold_final <= 1'b0;
      element_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      unit_type <= unit_type_next;
      acc <= acc_next;
      gath <= gath_next;
      lzc <= lzc_next;
      slc <= slc_next;
      li <= li_next;
      chroma <= chroma_next;
      if (step_go) begin
        if (is_end) begin
          bitcnt <= 3'd7;
          bits_done <= 1'b0;
        end else begin
          bitcnt <= 3'(bitcnt - 3'd1);
          if (bitcnt == 3'd0 && ent.last) begin
            bits_done <= 1'b1;
          end
        end
      end
      if (produce) begin
        hold_valid <= 1'b1;
        hold_final <= pop;
      end else if (hold_out) begin
        hold_valid <= 1'b0;
        hold_final <= 1'b0;
      end else if (pop && hold_valid) begin
        hold_final <= 1'b1;
      end
      if (hold_out) begin
        element_valid <= 1'b1;
      end else if (!element_stall) begin
        element_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prof <= prof_next;
    lev <= lev_next;
    if (produce) begin
      hold <= res;
    end
    if (hold_out) begin
      element_id <= hold.id;
      element_value <= hold.value;
      sub_layer <= hold.sub;
      flag_index <= hold.fidx;
      status <= hold.status;
      run_last <= hold_final;
    end
  end

  a_pos_legal: assert property (@(posedge clk) disable iff (rst)
    pos < hnp_pkg::POS_END || pos == hnp_pkg::POS_DONE)
    else $error("syntax position out of range");

  a_lzc_bound: assert property (@(posedge clk) disable iff (rst)
    lzc < 6'd32)
    else $error("leading zero count exceeded 31");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    li <= LIW'(MAX_SUB_LAYERS) && slc <= 3'(MAX_SUB_LAYERS - 1))
    else $error("sub-layer loop index out of range");

  a_unit_clear: assert property (@(posedge clk) disable iff (rst)
    (step_go && is_end && ent.last) |=> (pos == '0 && lzc == '0 && acc == '0))
    else $error("parse state not cleared at end of unit");

  a_hold_drain: assert property (@(posedge clk) disable iff (rst)
    (produce && hold_valid) |-> hold_out)
    else $error("pending result overwritten");

endmodule

### src/hevc_nal_header_parser.sv
// ----------------------------------------------------------------------------
// hevc_nal_header_parser
// HEVC NAL unit header and leading parameter set parser.
// ----------------------------------------------------------------------------
// Bytes of one NAL unit enter without the start code, one request per byte,
// and are queued (four deep) after emulation prevention bytes are marked.
// The syntax walker consumes one payload bit per cycle while it is not held.
// A byte that feeds the walker is popped with its last bit, but the final byte
// of a unit, or one in which the walker finishes before its last bit, is popped
// in a step of its own after the bits it feeds. Dropped bytes and bytes after
// the walker has finished are popped without feeding it. While a result waits
// behind a stalled output, the walker holds. Each result request carries one
// syntax element or status, and run_last marks the last element caused by a byte.
module hevc_nal_header_parser #(
  parameter int MAX_SUB_LAYERS = hnp_pkg::MAX_SUB_LAYERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        unit_end,
  output logic        element_valid,
  input  logic        element_stall,
  output logic [5:0]  element_id,
  output logic [31:0] element_value,
  output logic [2:0]  sub_layer,
  output logic [4:0]  flag_index,
  output logic [1:0]  status,
  output logic        run_last
);

  logic              queue_full;
  logic              push;
  hnp_pkg::q_entry_t push_entry;
  logic              pop;
  logic              not_empty;
  hnp_pkg::q_entry_t head_entry;

  hnp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .unit_end   (unit_end),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  hnp_queue #(
    .DEPTH (hnp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head_entry (head_entry)
  );

  hnp_back #(
    .MAX_SUB_LAYERS (MAX_SUB_LAYERS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .ent_valid     (not_empty),
    .ent           (head_entry),
    .pop           (pop),
    .element_valid (element_valid),
    .element_stall (element_stall),
    .element_id    (element_id),
    .element_value (element_value),
    .sub_layer     (sub_layer),
    .flag_index    (flag_index),
    .status        (status),
    .run_last      (run_last)
  );

endmodule
